[hw/rtl/sfd_pkg.sv]
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants, register indexes and the CRC-8 byte update for the
// stuffed frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int FLEN_W    = 6;   // width of the frame length result field
    localparam int DIDX_W    = 5;   // width of the data index result field

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ADDR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_BYTE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_MASK   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY   = 3'd5;

    // Register values after reset
    localparam logic [BYTE_W-1:0] RST_NODE_ADDR  = 8'd1;
    localparam logic [BYTE_W-1:0] RST_BCAST_ADDR = 8'd255;
    localparam logic [BYTE_W-1:0] RST_START_BYTE = 8'd126;
    localparam logic [BYTE_W-1:0] RST_ESC_BYTE   = 8'd125;
    localparam logic [BYTE_W-1:0] RST_ESC_MASK   = 8'd32;
    localparam logic [BYTE_W-1:0] RST_CRC_POLY   = 8'd7;

    localparam logic [BYTE_W-1:0] CRC_INIT  = 8'h00;
    localparam logic [BYTE_W-1:0] NO_DATA   = 8'h00;

    // Fold one byte into an MSB-first CRC-8
    function automatic logic [BYTE_W-1:0] crc8_update(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] data,
        input logic [BYTE_W-1:0] poly
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ poly;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/sfd_ram.sv]
// ----------------------------------------------------------------------------
// sfd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/sfd_desc_fifo.sv]
// ----------------------------------------------------------------------------
// sfd_desc_fifo
// Two-entry queue of frame descriptors between the parser and the emitter.
// ----------------------------------------------------------------------------
module sfd_desc_fifo #(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;

    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rptr];

    // Track the fill level
    always_comb begin
        n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    // Hold entries and advance the pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

[hw/rtl/sfd_frame_parser.sv]
// ----------------------------------------------------------------------------
// sfd_frame_parser
// Front end: holds the configuration registers, removes byte stuffing, walks
// the frame fields, checks the CRC and writes the payload into one of two
// RAM banks. A good frame leaves a descriptor in the queue.
// ----------------------------------------------------------------------------
module sfd_frame_parser
    import sfd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32,
    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1),
    localparam int IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
    localparam int ADDR_W = IDX_W + 1,
    localparam int DESC_W = 1 + LEN_W + BYTE_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 i_release,
    output logic                 o_desc_push,
    output logic [DESC_W-1:0]    o_desc,
    output logic                 o_ram_we,
    output logic [ADDR_W-1:0]    o_ram_waddr,
    output logic [BYTE_W-1:0]    o_ram_wdata
);

    typedef enum logic [2:0] {
        P_WAIT,
        P_ADDR,
        P_CMD,
        P_LEN,
        P_DATA,
        P_CRC
    } t_phase;

    typedef struct packed {
        logic              bank;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] cmd;
    } t_desc;

    // Configuration registers
    logic [BYTE_W-1:0] r_node_addr;
    logic [BYTE_W-1:0] r_bcast_addr;
    logic [BYTE_W-1:0] r_start_byte;
    logic [BYTE_W-1:0] r_esc_byte;
    logic [BYTE_W-1:0] r_esc_mask;
    logic [BYTE_W-1:0] r_crc_poly;

    // Parser state
    t_phase            r_phase,  n_phase;
    logic              r_esc,    n_esc;
    logic              r_len_hi, n_len_hi;
    logic [BYTE_W-1:0] r_len_lo, n_len_lo;
    logic [LEN_W-1:0]  r_len,    n_len;
    logic [LEN_W-1:0]  r_cnt,    n_cnt;
    logic [BYTE_W-1:0] r_crc,    n_crc;
    logic [BYTE_W-1:0] r_cmd,    n_cmd;
    logic              r_bank,   n_bank;
    logic [1:0]        r_owned,  n_owned;

    logic              w_accept;
    logic              w_proc;
    logic [BYTE_W-1:0] w_ub;
    logic [BYTE_W-1:0] w_crc_nx;
    logic [LEN_W-1:0]  w_cnt_inc;
    logic              w_good;
    t_desc             w_desc;

    // Both banks held by frames not yet drained: stall the line
    assign o_full   = (r_owned == 2'd2);
    assign w_accept = i_push && !o_full;

    // Strip stuffing: decide whether the byte enters the frame and its value
    always_comb begin
        w_proc = 1'b0;
        w_ub   = i_rx_byte;
        if (w_accept && (i_rx_byte != r_start_byte) && (r_phase != P_WAIT)) begin
            if (r_esc) begin
                w_ub   = i_rx_byte ^ r_esc_mask;
                w_proc = 1'b1;
            end else if (i_rx_byte != r_esc_byte) begin
                w_proc = 1'b1;
            end
        end
    end

    assign w_crc_nx  = crc8_update(r_crc, w_ub, r_crc_poly);
    assign w_cnt_inc = r_cnt + LEN_W'(1);

    // Walk the frame fields
    always_comb begin
        n_phase  = r_phase;
        n_esc    = r_esc;
        n_len_hi = r_len_hi;
        n_len_lo = r_len_lo;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_crc    = r_crc;
        n_cmd    = r_cmd;
        n_bank   = r_bank;
        w_good   = 1'b0;
        o_ram_we = 1'b0;

        if (w_accept) begin
            if (i_rx_byte == r_start_byte) begin
                // Resynchronize on every start byte
                n_phase  = P_ADDR;
                n_esc    = 1'b0;
                n_len_hi = 1'b0;
                n_cnt    = '0;
                n_crc    = CRC_INIT;
            end else if (r_phase != P_WAIT) begin
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (i_rx_byte == r_esc_byte) begin
                    n_esc = 1'b1;
                end
            end
        end

        if (w_proc) begin
            unique case (r_phase)
                P_ADDR: begin
                    if (w_ub == r_node_addr || w_ub == r_bcast_addr) begin
                        n_crc   = w_crc_nx;
                        n_phase = P_CMD;
                    end else begin
                        n_phase = P_WAIT;
                        n_crc   = CRC_INIT;
                    end
                end
                P_CMD: begin
                    n_cmd   = w_ub;
                    n_crc   = w_crc_nx;
                    n_phase = P_LEN;
                end
                P_LEN: begin
                    n_crc = w_crc_nx;
                    if (!r_len_hi) begin
                        n_len_lo = w_ub;
                        n_len_hi = 1'b1;
                    end else begin
                        n_len_hi = 1'b0;
                        if (w_ub == NO_DATA && r_len_lo == NO_DATA) begin
                            n_phase = P_CRC;
                        end else if (w_ub == NO_DATA
                                     && r_len_lo <= BYTE_W'(MAX_PAYLOAD)) begin
                            n_len   = r_len_lo[LEN_W-1:0];
                            n_phase = P_DATA;
                        end else begin
                            // Oversize frame: drop it
                            n_phase = P_WAIT;
                            n_crc   = CRC_INIT;
                        end
                    end
                end
                P_DATA: begin
                    n_crc    = w_crc_nx;
                    o_ram_we = 1'b1;
                    n_cnt    = w_cnt_inc;
                    if (w_cnt_inc >= r_len) begin
                        n_phase = P_CRC;
                    end
                end
                P_CRC: begin
                    n_phase = P_WAIT;
                    n_crc   = CRC_INIT;
                    if (r_crc == w_ub) begin
                        w_good = 1'b1;
                        n_bank = ~r_bank;
                    end
                end
                default: begin
                    n_phase = P_WAIT;
                end
            endcase
        end
    end

    // Count banks held by queued or draining frames
    always_comb begin
        n_owned = r_owned + {1'b0, w_good} - {1'b0, i_release};
    end

    assign w_desc.bank  = r_bank;
    assign w_desc.len   = r_cnt;
    assign w_desc.cmd   = r_cmd;
    assign o_desc       = w_desc;
    assign o_desc_push  = w_good;
    assign o_ram_waddr  = {r_bank, r_cnt[IDX_W-1:0]};
    assign o_ram_wdata  = w_ub;

    // Hold parser state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= P_WAIT;
            r_esc        <= 1'b0;
            r_len_hi     <= 1'b0;
            r_len_lo     <= '0;
            r_len        <= '0;
            r_cnt        <= '0;
            r_crc        <= CRC_INIT;
            r_cmd        <= '0;
            r_bank       <= 1'b0;
            r_owned      <= 2'd0;
            r_node_addr  <= RST_NODE_ADDR;
            r_bcast_addr <= RST_BCAST_ADDR;
            r_start_byte <= RST_START_BYTE;
            r_esc_byte   <= RST_ESC_BYTE;
            r_esc_mask   <= RST_ESC_MASK;
            r_crc_poly   <= RST_CRC_POLY;
        end else begin
            r_phase  <= n_phase;
            r_esc    <= n_esc;
            r_len_hi <= n_len_hi;
            r_len_lo <= n_len_lo;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_crc    <= n_crc;
            r_cmd    <= n_cmd;
            r_bank   <= n_bank;
            r_owned  <= n_owned;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_NODE_ADDR:  r_node_addr  <= i_cfg_data;
                    CFG_BCAST_ADDR: r_bcast_addr <= i_cfg_data;
                    CFG_START_BYTE: r_start_byte <= i_cfg_data;
                    CFG_ESC_BYTE:   r_esc_byte   <= i_cfg_data;
                    CFG_ESC_MASK:   r_esc_mask   <= i_cfg_data;
                    CFG_CRC_POLY:   r_crc_poly   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

[hw/rtl/sfd_result_emitter.sv]
// ----------------------------------------------------------------------------
// sfd_result_emitter
// Back end: takes one frame descriptor at a time and reads its payload bank
// out of the RAM, one result per transfer.
// ----------------------------------------------------------------------------
module sfd_result_emitter
    import sfd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32,
    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1),
    localparam int IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
    localparam int ADDR_W = IDX_W + 1,
    localparam int DESC_W = 1 + LEN_W + BYTE_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_desc_empty,
    input  logic [DESC_W-1:0] i_desc,
    output logic              o_desc_pop,
    output logic              o_rd_en,
    output logic [ADDR_W-1:0] o_rd_addr,
    input  logic [BYTE_W-1:0] i_rd_data,
    output logic              o_release,
    output logic              empty,
    input  logic              pop,
    output logic [BYTE_W-1:0] o_command,
    output logic [FLEN_W-1:0] o_frame_length,
    output logic              o_has_data,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic [DIDX_W-1:0] o_data_index,
    output logic              o_last
);

    typedef enum logic {
        B_IDLE,
        B_OUT
    } t_bstate;

    typedef struct packed {
        logic              bank;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] cmd;
    } t_desc;

    t_bstate           r_state;
    logic              r_bank;
    logic [LEN_W-1:0]  r_len;
    logic [BYTE_W-1:0] r_cmd;
    logic [IDX_W-1:0]  r_idx;

    t_desc                    w_desc;
    logic                     w_take;
    logic                     w_last;
    logic [LEN_W-1:0]         w_idx_ext;
    logic [LEN_W+FLEN_W-1:0]  w_len_wide;
    logic [IDX_W+DIDX_W-1:0]  w_idx_wide;

    assign w_desc    = i_desc;
    assign empty     = (r_state != B_OUT);
    assign w_take    = pop && (r_state == B_OUT);
    assign w_idx_ext = LEN_W'(r_idx);
    assign w_last    = (r_len == '0) || (w_idx_ext + LEN_W'(1) == r_len);

    // Issue payload reads: first byte on load of a non-empty frame, next byte on each transfer but the last
    always_comb begin
        o_desc_pop = (r_state == B_IDLE) && !i_desc_empty;
        o_release  = w_take && w_last;
        o_rd_en    = 1'b0;
        o_rd_addr  = {r_bank, r_idx};
        if (o_desc_pop) begin
            o_rd_en   = (w_desc.len != '0);
            o_rd_addr = {w_desc.bank, {IDX_W{1'b0}}};
        end else if (w_take && !w_last) begin
            o_rd_en   = 1'b1;
            o_rd_addr = {r_bank, r_idx + IDX_W'(1)};
        end
    end

    // Hold the active frame and advance through its payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_bank  <= 1'b0;
            r_len   <= '0;
            r_cmd   <= '0;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (o_desc_pop) begin
                        r_bank  <= w_desc.bank;
                        r_len   <= w_desc.len;
                        r_cmd   <= w_desc.cmd;
                        r_idx   <= '0;
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (w_take) begin
                        if (w_last) begin
                            r_state <= B_IDLE;
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    // Drive the result fields, truncated to their port widths
    assign w_len_wide     = {{FLEN_W{1'b0}}, r_len};
    assign w_idx_wide     = {{DIDX_W{1'b0}}, r_idx};
    assign o_command      = r_cmd;
    assign o_frame_length = w_len_wide[FLEN_W-1:0];
    assign o_has_data     = (r_len != '0);
    assign o_data_byte    = o_has_data ? i_rd_data : NO_DATA;
    assign o_data_index   = w_idx_wide[DIDX_W-1:0];
    assign o_last         = w_last;

endmodule

[hw/rtl/stuffed_frame_decoder_crc8.sv]
// ----------------------------------------------------------------------------
// stuffed_frame_decoder_crc8
// Byte-stuffed frame decoder with CRC-8 check. One received line byte is
// accepted per cycle while full is low. A frame whose CRC matches reaches the
// result side through the descriptor queue and the emitter state register
// when that side is idle, and comes out as one result per payload byte (one
// empty result for a zero-length frame), one result per cycle while pop is
// held, with an idle state between frames, read from a payload RAM with
// registered read. The RAM has two banks of MAX_PAYLOAD bytes: full rises
// once two good frames are waiting or draining and falls in the cycle after
// the last result of the older one is popped. The payload RAM needs no
// clearing after reset.
// ----------------------------------------------------------------------------
module stuffed_frame_decoder_crc8
    import sfd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    output logic                 empty,
    input  logic                 pop,
    output logic [BYTE_W-1:0]    o_command,
    output logic [FLEN_W-1:0]    o_frame_length,
    output logic                 o_has_data,
    output logic [BYTE_W-1:0]    o_data_byte,
    output logic [DIDX_W-1:0]    o_data_index,
    output logic                 o_last
);

    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int ADDR_W = IDX_W + 1;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int DESC_W = 1 + LEN_W + BYTE_W;

    logic              w_release;
    logic              w_desc_push;
    logic [DESC_W-1:0] w_desc_in;
    logic              w_desc_pop;
    logic              w_desc_empty;
    logic [DESC_W-1:0] w_desc_out;
    logic              w_ram_we;
    logic [ADDR_W-1:0] w_ram_waddr;
    logic [BYTE_W-1:0] w_ram_wdata;
    logic              w_ram_re;
    logic [ADDR_W-1:0] w_ram_raddr;
    logic [BYTE_W-1:0] w_ram_rdata;

    sfd_frame_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_byte   (i_rx_byte),
        .i_push      (push),
        .o_full      (full),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_release   (w_release),
        .o_desc_push (w_desc_push),
        .o_desc      (w_desc_in),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata)
    );

    sfd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    sfd_desc_fifo #(
        .WIDTH (DESC_W)
    ) u_desc_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_desc_push),
        .i_data  (w_desc_in),
        .i_pop   (w_desc_pop),
        .o_empty (w_desc_empty),
        .o_data  (w_desc_out)
    );

    sfd_result_emitter #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_emitter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_desc_empty   (w_desc_empty),
        .i_desc         (w_desc_out),
        .o_desc_pop     (w_desc_pop),
        .o_rd_en        (w_ram_re),
        .o_rd_addr      (w_ram_raddr),
        .i_rd_data      (w_ram_rdata),
        .o_release      (w_release),
        .empty          (empty),
        .pop            (pop),
        .o_command      (o_command),
        .o_frame_length (o_frame_length),
        .o_has_data     (o_has_data),
        .o_data_byte    (o_data_byte),
        .o_data_index   (o_data_index),
        .o_last         (o_last)
    );

endmodule

[hw/rtl/sfd_checker.sv]
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks for the stuffed frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker
    import sfd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 push,
    input logic                 full,
    input logic [BYTE_W-1:0]    i_rx_byte,
    input logic                 i_cfg_wr_en,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [BYTE_W-1:0]    i_cfg_data,
    input logic                 empty,
    input logic                 pop,
    input logic [BYTE_W-1:0]    o_command,
    input logic [FLEN_W-1:0]    o_frame_length,
    input logic                 o_has_data,
    input logic [BYTE_W-1:0]    o_data_byte,
    input logic [DIDX_W-1:0]    o_data_index,
    input logic                 o_last
);

    // Both sides come out of reset open and idle
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queue sides not idle after reset");

    // An empty-frame result is a lone, zeroed last result
    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_has_data |->
            o_last && o_data_byte == NO_DATA && o_data_index == '0
            && o_frame_length == '0)
        else $error("malformed empty-frame result");

    // Within a frame, the next result follows with the same command
    a_run_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !empty && !o_last |=>
            !empty && o_command == $past(o_command)
            && o_data_index == DIDX_W'($past(o_data_index) + DIDX_W'(1)))
        else $error("payload run broken inside a frame");

    // A waiting result holds until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=>
            !empty && $stable(o_data_byte) && $stable(o_data_index)
            && $stable(o_last))
        else $error("waiting result changed");

endmodule

bind stuffed_frame_decoder_crc8 sfd_checker u_sfd_checker (.*);
